// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/tepd_pkg.sv =====
// ---------------------------------------------------------------------------
// tepd_pkg
// Shared constants and types of the two-erasure parity decoder.
// ---------------------------------------------------------------------------
package tepd_pkg;

	localparam int CFG_W            = 5;   // data_count register width
	localparam int IDX_OUT_W        = 4;   // index fields of a result
	localparam int CNT_W            = 2;   // repaired_count width
	localparam int DATA_COUNT_RESET = 16;

	typedef enum logic [1:0] {
		STATUS_INTACT        = 2'd0,
		STATUS_REPAIRED      = 2'd1,
		STATUS_UNRECOVERABLE = 2'd2
	} status_t;

endpackage

// ===== sv/tepd_ifs.sv =====
// ---------------------------------------------------------------------------
// tepd_ifs
// Channel interfaces: received rows, decoded results and the config write.
// ---------------------------------------------------------------------------
interface tepd_item_if #(
	parameter int SYMBOL_BITS = 32
);
	logic                   valid;
	logic                   ready;
	logic [SYMBOL_BITS-1:0] symbol;
	logic                   erased;

	modport source (output valid, output symbol, output erased, input ready);
	modport sink   (input valid, input symbol, input erased, output ready);
endinterface

interface tepd_result_if import tepd_pkg::*; #(
	parameter int SYMBOL_BITS = 32
);
	logic                   valid;
	logic                   ready;
	logic [1:0]             status;
	logic [CNT_W-1:0]       repaired_count;
	logic [IDX_OUT_W-1:0]   first_index;
	logic [SYMBOL_BITS-1:0] first_value;
	logic [IDX_OUT_W-1:0]   second_index;
	logic [SYMBOL_BITS-1:0] second_value;

	modport source (output valid, output status, output repaired_count,
		output first_index, output first_value, output second_index,
		output second_value, input ready);
	modport sink   (input valid, input status, input repaired_count,
		input first_index, input first_value, input second_index,
		input second_value, output ready);
endinterface

interface tepd_cfg_if import tepd_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data_count;

	modport source (output valid, output data_count, input ready);
	modport sink   (input valid, input data_count, output ready);
endinterface

// ===== sv/tepd_cfg.sv =====
// ---------------------------------------------------------------------------
// tepd_cfg
// data_count register, stored as the clamped word geometry (k, t, last row).
// ---------------------------------------------------------------------------
module tepd_cfg import tepd_pkg::*; #(
	parameter int MAX_DATA = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        wr_valid,
	input  logic [CFG_W-1:0]                            wr_data,
	output logic [$clog2(MAX_DATA+1)-1:0]               k,
	output logic [$clog2($clog2(MAX_DATA)+1)-1:0]       t,
	output logic [$clog2(MAX_DATA+$clog2(MAX_DATA)+2)-1:0] last
);

	localparam int G     = $clog2(MAX_DATA);
	localparam int KW    = $clog2(MAX_DATA+1);
	localparam int TW    = $clog2(G+1);
	localparam int PW    = $clog2(MAX_DATA+G+2);
	localparam int DW    = (KW > CFG_W) ? KW : CFG_W;
	localparam int K_RST = (MAX_DATA < DATA_COUNT_RESET) ? MAX_DATA : DATA_COUNT_RESET;
	localparam int T_RST = $clog2(K_RST);

	logic [KW-1:0] k_q, k_nxt;
	logic [TW-1:0] t_q, t_nxt;
	logic [PW-1:0] last_q;
	logic [DW:0]   dv;

	// number of index bits: smallest r with 2^r >= k
	function automatic logic [TW-1:0] index_bits(input logic [KW-1:0] kv);
		logic [TW-1:0] r;
		r = '0;
		for (int i = 0; i < G; i++) begin
			if ({1'b0, kv} > ((KW+1)'(1) << i))
				r = TW'(i + 1);
		end
		return r;
	endfunction

	always_comb begin
		dv = (DW+1)'(wr_data);
		if (dv < (DW+1)'(2))
			k_nxt = KW'(2);
		else if (dv > (DW+1)'(MAX_DATA))
			k_nxt = KW'(MAX_DATA);
		else
			k_nxt = KW'(dv);
		t_nxt = index_bits(k_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= KW'(K_RST);
			t_q    <= TW'(T_RST);
			last_q <= PW'(K_RST + T_RST + 1);
		end else if (wr_valid) begin
			k_q    <= k_nxt;
			t_q    <= t_nxt;
			last_q <= PW'(k_nxt) + PW'(t_nxt) + PW'(1);
		end
	end

	assign k    = k_q;
	assign t    = t_q;
	assign last = last_q;

endmodule

// ===== sv/tepd_accum.sv =====
// ---------------------------------------------------------------------------
// tepd_accum
// Row register, XOR accumulators and loss bookkeeping; forms the result on
// the last row of a codeword column.
// ---------------------------------------------------------------------------
module tepd_accum import tepd_pkg::*; #(
	parameter int MAX_DATA    = 16,
	parameter int SYMBOL_BITS = 32
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic [$clog2(MAX_DATA+1)-1:0]                  k,
	input  logic [$clog2($clog2(MAX_DATA)+1)-1:0]          t,
	input  logic [$clog2(MAX_DATA+$clog2(MAX_DATA)+2)-1:0] last,
	input  logic                                           in_valid,
	output logic                                           in_ready,
	input  logic [SYMBOL_BITS-1:0]                         in_symbol,
	input  logic                                           in_erased,
	output logic                                           res_valid,
	input  logic                                           res_ready,
	output logic [2+CNT_W+2*IDX_OUT_W+2*SYMBOL_BITS-1:0]   res_data
);

	localparam int G     = $clog2(MAX_DATA);
	localparam int IDX_W = G;
	localparam int TW    = $clog2(G+1);
	localparam int PW    = $clog2(MAX_DATA+G+2);
	localparam int HB_W  = (G > 1) ? $clog2(G) : 1;
	localparam int SB    = SYMBOL_BITS;

	// row register
	logic          valid_s1;
	logic [SB-1:0] symbol_s1;
	logic          erased_s1;

	// word state
	logic [PW-1:0]    pos_q;
	logic [1:0]       loss_q, loss_nxt;
	logic [1:0]       lost_data_q, lost_data_nxt;
	logic [IDX_W-1:0] lower_q, lower_nxt;
	logic [IDX_W-1:0] upper_q, upper_nxt;
	logic [SB-1:0]    sum_p0_q, sum_p0_nxt;
	logic [SB-1:0]    sum_copy_q, sum_copy_nxt;
	logic [SB-1:0]    grp_q [G];
	logic [SB-1:0]    grp_nxt [G];
	logic             p0_lost_q, p0_lost_nxt;

	logic          end_row, is_data, is_p0, is_grp, advance;
	logic [PW-1:0] k_p, kt_p, grp_sel;

	status_t          status;
	logic [CNT_W-1:0] count;
	logic [IDX_W-1:0] idx1, idx2, diff;
	logic [SB-1:0]    val1, val2;
	logic [HB_W-1:0]  hb;

	assign k_p     = PW'(k);
	assign kt_p    = k_p + PW'(t);
	assign end_row = pos_q >= last;
	assign is_data = pos_q < k_p;
	assign is_p0   = pos_q == k_p;
	assign is_grp  = (pos_q > k_p) && (pos_q <= kt_p);
	assign grp_sel = kt_p - pos_q;   // parity row k+i covers index bit t-i

	assign res_valid = valid_s1 && end_row;
	assign advance   = valid_s1 && (!end_row || res_ready);
	assign in_ready  = !valid_s1 || advance;

	always_comb begin
		loss_nxt      = loss_q;
		lost_data_nxt = lost_data_q;
		lower_nxt     = lower_q;
		upper_nxt     = upper_q;
		sum_p0_nxt    = sum_p0_q;
		sum_copy_nxt  = sum_copy_q;
		grp_nxt       = grp_q;
		p0_lost_nxt   = p0_lost_q;
		if (erased_s1) begin
			if (loss_q != 2'd3)
				loss_nxt = loss_q + 2'd1;
			if (is_data) begin
				if (lost_data_q == 2'd0)
					lower_nxt = pos_q[IDX_W-1:0];
				else if (lost_data_q == 2'd1)
					upper_nxt = pos_q[IDX_W-1:0];
				if (lost_data_q != 2'd3)
					lost_data_nxt = lost_data_q + 2'd1;
			end else if (is_p0) begin
				p0_lost_nxt = 1'b1;
			end
		end else if (is_data) begin
			sum_p0_nxt   = sum_p0_q ^ symbol_s1;
			sum_copy_nxt = sum_copy_q ^ symbol_s1;
			for (int b = 0; b < G; b++) begin
				if ((TW'(b) < t) && pos_q[b])
					grp_nxt[b] = grp_q[b] ^ symbol_s1;
			end
		end else if (is_p0) begin
			sum_p0_nxt = sum_p0_q ^ symbol_s1;
		end else if (is_grp) begin
			for (int b = 0; b < G; b++) begin
				if (grp_sel == PW'(b))
					grp_nxt[b] = grp_q[b] ^ symbol_s1;
			end
		end else begin
			sum_copy_nxt = sum_copy_q ^ symbol_s1;
		end
	end

	// highest index bit where the two lost rows differ
	always_comb begin
		diff = lower_nxt ^ upper_nxt;
		hb   = '0;
		for (int b = 0; b < G; b++) begin
			if (diff[b])
				hb = HB_W'(b);
		end
	end

	always_comb begin
		status = STATUS_INTACT;
		count  = '0;
		idx1   = '0;
		idx2   = '0;
		val1   = '0;
		val2   = '0;
		if (lost_data_nxt == 2'd0) begin
			status = STATUS_INTACT;
		end else if (loss_nxt == 2'd3) begin
			status = STATUS_UNRECOVERABLE;
		end else if (lost_data_nxt == 2'd1) begin
			status = STATUS_REPAIRED;
			count  = CNT_W'(1);
			idx1   = lower_nxt;
			val1   = p0_lost_nxt ? sum_copy_nxt : sum_p0_nxt;
		end else begin
			status = STATUS_REPAIRED;
			count  = CNT_W'(2);
			idx1   = lower_nxt;
			idx2   = upper_nxt;
			val2   = grp_nxt[hb];
			val1   = sum_p0_nxt ^ grp_nxt[hb];
		end
	end

	assign res_data = {status, count, IDX_OUT_W'(idx1), val1, IDX_OUT_W'(idx2), val2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			symbol_s1 <= in_symbol;
			erased_s1 <= in_erased;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			loss_q      <= '0;
			lost_data_q <= '0;
			lower_q     <= '0;
			upper_q     <= '0;
			sum_p0_q    <= '0;
			sum_copy_q  <= '0;
			grp_q       <= '{default: '0};
			p0_lost_q   <= 1'b0;
		end else if (advance) begin
			if (end_row) begin
				pos_q       <= '0;
				loss_q      <= '0;
				lost_data_q <= '0;
				lower_q     <= '0;
				upper_q     <= '0;
				sum_p0_q    <= '0;
				sum_copy_q  <= '0;
				grp_q       <= '{default: '0};
				p0_lost_q   <= 1'b0;
			end else begin
				pos_q       <= pos_q + PW'(1);
				loss_q      <= loss_nxt;
				lost_data_q <= lost_data_nxt;
				lower_q     <= lower_nxt;
				upper_q     <= upper_nxt;
				sum_p0_q    <= sum_p0_nxt;
				sum_copy_q  <= sum_copy_nxt;
				grp_q       <= grp_nxt;
				p0_lost_q   <= p0_lost_nxt;
			end
		end
	end

endmodule

// ===== sv/tepd_outbuf.sv =====
// ---------------------------------------------------------------------------
// tepd_outbuf
// Result register with a skid entry, so the row side never waits on a
// stalled result in the same cycle.
// ---------------------------------------------------------------------------
module tepd_outbuf #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic             main_valid_q, skid_valid_q;
	logic [WIDTH-1:0] main_q, skid_q;
	logic             push, main_free;

	assign push_ready = !skid_valid_q;
	assign push       = push_valid && push_ready;
	assign main_free  = out_ready || !main_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = main_valid_q;
	assign out_data  = main_q;

endmodule

// ===== sv/two_erasure_parity_decoder.sv =====
// ---------------------------------------------------------------------------
// two_erasure_parity_decoder
// Recovers up to two erased data symbols of an XOR-parity codeword column.
// ---------------------------------------------------------------------------
// Takes one row of a codeword column per clock while item.ready is high: k data
// rows, P0, t = ceil(log2 k) bit-group parities, then the copy of P0, each with
// an erased flag. A row passes the row register and then updates the XOR
// accumulators; on the last row of the column the result is written to the
// result register. A stalled result is held with one skid entry behind it, so
// rows keep flowing while it waits, until a further result finds that entry full.
// data_count is clamped to 2..MAX_DATA and acts on the row in the row register
// once written; write it between columns. Value fields are SYMBOL_BITS wide.
module two_erasure_parity_decoder import tepd_pkg::*; #(
	parameter int MAX_DATA    = 16,
	parameter int SYMBOL_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	tepd_cfg_if.sink          cfg,
	tepd_item_if.sink         item,
	tepd_result_if.source     result
);

	localparam int G     = $clog2(MAX_DATA);
	localparam int KW    = $clog2(MAX_DATA+1);
	localparam int TW    = $clog2(G+1);
	localparam int PW    = $clog2(MAX_DATA+G+2);
	localparam int RES_W = 2 + CNT_W + 2*IDX_OUT_W + 2*SYMBOL_BITS;

	logic [KW-1:0]    k;
	logic [TW-1:0]    t;
	logic [PW-1:0]    last;
	logic             res_valid, res_ready;
	logic [RES_W-1:0] res_data, out_data;

	assign cfg.ready = 1'b1;

	tepd_cfg #(
		.MAX_DATA (MAX_DATA)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg.valid),
		.wr_data  (cfg.data_count),
		.k        (k),
		.t        (t),
		.last     (last)
	);

	tepd_accum #(
		.MAX_DATA    (MAX_DATA),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.k         (k),
		.t         (t),
		.last      (last),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_symbol (item.symbol),
		.in_erased (item.erased),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	tepd_outbuf #(
		.WIDTH (RES_W)
	) u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (res_valid),
		.push_ready (res_ready),
		.push_data  (res_data),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_data   (out_data)
	);

	assign {result.status, result.repaired_count, result.first_index,
		result.first_value, result.second_index, result.second_value} = out_data;

endmodule

// ===== sv/tepd_checker.sv =====
// ---------------------------------------------------------------------------
// tepd_checker
// Port-level checks on the result channel of the decoder.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tepd_checker import tepd_pkg::*; #(
	parameter int SYMBOL_BITS = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   res_valid,
	input logic                   res_ready,
	input logic [1:0]             status,
	input logic [CNT_W-1:0]       repaired_count,
	input logic [IDX_OUT_W-1:0]   first_index,
	input logic [SYMBOL_BITS-1:0] first_value,
	input logic [IDX_OUT_W-1:0]   second_index,
	input logic [SYMBOL_BITS-1:0] second_value
);

	// a stalled result holds its status, count and values
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(status) && $stable(repaired_count) && $stable(first_value) && $stable(second_value))

	// intact or lost columns carry no repair
	`ASSERT_IMPLY(a_no_repair, clk, arst_n, res_valid && (status == STATUS_INTACT || status == STATUS_UNRECOVERABLE), repaired_count == '0 && first_index == '0 && first_value == '0 && second_value == '0)

	// a repair recovers one or two symbols
	`ASSERT_IMPLY(a_repair_count, clk, arst_n, res_valid && status == STATUS_REPAIRED, repaired_count == CNT_W'(1) || repaired_count == CNT_W'(2))

	// single repair leaves the second slot empty
	`ASSERT_IMPLY(a_single_slot, clk, arst_n, res_valid && repaired_count == CNT_W'(1), second_index == '0 && second_value == '0)

endmodule

bind two_erasure_parity_decoder tepd_checker #(
	.SYMBOL_BITS (SYMBOL_BITS)
) u_tepd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.status         (result.status),
	.repaired_count (result.repaired_count),
	.first_index    (result.first_index),
	.first_value    (result.first_value),
	.second_index   (result.second_index),
	.second_value   (result.second_value)
);
